// ===== rtl/core/rnka_pkg.sv =====
// Shared constants and controller/datapath handshake types for rank assignment.
package rnka_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int POS_W    = 6;
  localparam int RANK_W   = 7;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } rnka_state_t;

  typedef struct packed {
    logic load;        // store the accepted word
    logic start_rank;  // final word accepted: begin ranking at position 0
    logic scan_en;     // walk the store and compare
    logic capture;     // latch the finished rank into the output register
    logic next_item;   // result taken, move to the next position
    logic finish;      // last result taken, empty the set
  } rnka_cmd_t;

  typedef struct packed {
    logic scan_done;   // all compares for the current position counted
    logic last_item;   // current position is the last stored one
  } rnka_sts_t;

endpackage

// ===== rtl/core/rnka_in_if.sv =====
// Input channel: one sample word per handshake.
interface rnka_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [rnka_pkg::DATA_W-1:0] sample;
  logic                              final_sample;

  modport source (output valid, output sample, output final_sample, input ready);
  modport sink (input valid, input sample, input final_sample, output ready);
endinterface

// ===== rtl/core/rnka_out_if.sv =====
// Output channel: one ranked word per handshake.
interface rnka_out_if;
  logic                        valid;
  logic                        ready;
  logic [rnka_pkg::POS_W-1:0]  position;
  logic [rnka_pkg::RANK_W-1:0] rank;
  logic                        final_rank;
  logic                        overflowed;

  modport source (output valid, output position, output rank, output final_rank,
                  output overflowed, input ready);
  modport sink (input valid, input position, input rank, input final_rank,
                input overflowed, output ready);
endinterface

// ===== rtl/core/rank_assignment.sv =====
// Top level of the rank assignment block: controller, datapath and checks.
// Samples load at one word per cycle into a 64-entry store in arrival order;
// a word beyond capacity is dropped and the set is marked overflowed. The word
// flagged final_sample is stored like the rest and then the block ranks every
// stored value in storage order, emitting one word per value with its rank
// (1 plus the number of strictly smaller stored values; equal values share a
// rank). For each result the probe read port walks the whole store with one
// signed compare per cycle. No sample is accepted from the final word until the
// last result is taken, after which the set is empty. Right after reset the
// block is ready at once.
module rank_assignment (
  input logic        clk,
  input logic        rst,
  rnka_in_if.sink    samples,
  rnka_out_if.source results
);

  rnka_pkg::rnka_cmd_t cmd;
  rnka_pkg::rnka_sts_t sts;

  rnka_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_final  (samples.final_sample),
    .in_ready  (samples.ready),
    .out_ready (results.ready),
    .out_valid (results.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  rnka_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .sample     (samples.sample),
    .position   (results.position),
    .rank       (results.rank),
    .final_rank (results.final_rank),
    .overflowed (results.overflowed)
  );

  // Loading and emitting never overlap
  assert property (@(posedge clk) disable iff (rst) !(samples.ready && results.valid))
    else $error("input ready while a result is shown");

  // A shown rank is always in range
  assert property (@(posedge clk) disable iff (rst)
      results.valid |-> (results.rank != '0) &&
                        (results.rank <= rnka_pkg::RANK_W'(rnka_pkg::CAPACITY)))
    else $error("rank out of range");

  // Taking the last result reopens the input
  assert property (@(posedge clk) disable iff (rst)
      results.valid && results.ready && results.final_rank |=> samples.ready)
    else $error("input not ready after last result");

  // A final sample starts ranking, so input closes next cycle
  assert property (@(posedge clk) disable iff (rst)
      samples.valid && samples.ready && samples.final_sample |=> !samples.ready)
    else $error("input still open after final sample");

endmodule

// ===== rtl/core/rnka_ctrl.sv =====
// Controller state machine: load, scan the store, emit one word per position.
module rnka_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_final,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  input  rnka_pkg::rnka_sts_t sts,
  output rnka_pkg::rnka_cmd_t cmd
);

  rnka_pkg::rnka_state_t state;
  rnka_pkg::rnka_state_t state_next;
  logic                  out_take;

  assign in_ready  = (state == rnka_pkg::S_IDLE);
  assign out_valid = (state == rnka_pkg::S_EMIT);
  assign out_take  = out_valid && out_ready;

  // Decode commands for the datapath
  always_comb begin
    cmd            = '0;
    cmd.load       = in_ready && in_valid;
    cmd.start_rank = in_ready && in_valid && in_final;
    cmd.scan_en    = (state == rnka_pkg::S_SCAN);
    cmd.capture    = (state == rnka_pkg::S_SCAN) && sts.scan_done;
    cmd.next_item  = out_take && !sts.last_item;
    cmd.finish     = out_take && sts.last_item;
  end

  // Advance the state
  always_comb begin
    state_next = state;
    case (state)
      rnka_pkg::S_IDLE: begin
        if (in_valid && in_final) state_next = rnka_pkg::S_SCAN;
      end
      rnka_pkg::S_SCAN: begin
        if (sts.scan_done) state_next = rnka_pkg::S_EMIT;
      end
      rnka_pkg::S_EMIT: begin
        if (out_take) state_next = sts.last_item ? rnka_pkg::S_IDLE : rnka_pkg::S_SCAN;
      end
      default: state_next = rnka_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rnka_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/rnka_dpath.sv =====
// Datapath: value store, compare counter and output register.
module rnka_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  rnka_pkg::rnka_cmd_t                 cmd,
  output rnka_pkg::rnka_sts_t                 sts,
  input  logic signed [rnka_pkg::DATA_W-1:0]  sample,
  output logic [rnka_pkg::POS_W-1:0]          position,
  output logic [rnka_pkg::RANK_W-1:0]         rank,
  output logic                                final_rank,
  output logic                                overflowed
);

  logic signed [rnka_pkg::DATA_W-1:0] mem [rnka_pkg::CAPACITY];
  logic signed [rnka_pkg::DATA_W-1:0] pivot;
  logic signed [rnka_pkg::DATA_W-1:0] probe;
  logic [rnka_pkg::CNT_W-1:0]         count;
  logic                               overflow_flag;
  logic [rnka_pkg::ADDR_W-1:0]        cur;
  logic [rnka_pkg::CNT_W-1:0]         scan;
  logic                               cmp_valid;
  logic [rnka_pkg::CNT_W-1:0]         smaller;
  logic                               issue;
  logic                               has_room;
  logic                               last_item;

  assign has_room  = (count < rnka_pkg::CNT_W'(rnka_pkg::CAPACITY));
  assign issue     = cmd.scan_en && (scan < count);
  assign last_item = ((rnka_pkg::CNT_W'(cur) + rnka_pkg::CNT_W'(1)) == count);

  assign sts.scan_done = cmd.scan_en && (scan == count) && !cmp_valid;
  assign sts.last_item = last_item;

  // Store writes and the two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.load && has_room) begin
      mem[count[rnka_pkg::ADDR_W-1:0]] <= sample;
    end
    pivot <= mem[cur];
    probe <= mem[scan[rnka_pkg::ADDR_W-1:0]];
  end

  // Fill count and overflow flag
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      count         <= '0;
      overflow_flag <= 1'b0;
    end else if (cmd.load) begin
      if (has_room) begin
        count <= count + rnka_pkg::CNT_W'(1);
      end else begin
        overflow_flag <= 1'b1;
      end
    end
  end

  // Walk the store and count strictly smaller values
  always_ff @(posedge clk) begin
    if (rst) begin
      cur       <= '0;
      scan      <= '0;
      cmp_valid <= 1'b0;
      smaller   <= '0;
    end else if (cmd.start_rank || cmd.next_item) begin
      cur       <= cmd.start_rank ? '0 : cur + rnka_pkg::ADDR_W'(1);
      scan      <= '0;
      cmp_valid <= 1'b0;
      smaller   <= '0;
    end else begin
      cmp_valid <= issue;
      if (issue) begin
        scan <= scan + rnka_pkg::CNT_W'(1);
      end
      if (cmp_valid && (probe < pivot)) begin
        smaller <= smaller + rnka_pkg::CNT_W'(1);
      end
    end
  end

  // Hold the finished word until it is taken
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      position   <= rnka_pkg::POS_W'(cur);
      rank       <= rnka_pkg::RANK_W'(smaller) + rnka_pkg::RANK_W'(1);
      final_rank <= last_item;
      overflowed <= overflow_flag;
    end
  end

endmodule

// ===== tb/sv/rank_assignment_tb.sv =====
// Self-checking testbench for the rank assignment block.
`timescale 1ns / 100ps

module rank_assignment_tb;

  localparam int CLK_HALF   = 5;
  localparam int RST_CYCLES = 4;
  // no word moves for at most about one rank scan plus a stall burst
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = rnka_pkg::CAPACITY + 8;

  typedef struct packed {
    logic [rnka_pkg::POS_W-1:0]  position;
    logic [rnka_pkg::RANK_W-1:0] rank;
    logic                        final_rank;
    logic                        overflowed;
  } rank_word_t;

  typedef logic signed [rnka_pkg::DATA_W-1:0] sample_t;

  logic clk;
  logic rst;

  rnka_in_if  samples_ch ();
  rnka_out_if results_ch ();

  rank_assignment u_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .results (results_ch)
  );

  // shadow of the block's set
  sample_t          set_values [rnka_pkg::CAPACITY];
  int unsigned      set_count;
  logic             set_dropped;
  rank_word_t       pending_ranks [$];

  bit               src_idle_en;
  bit               snk_stall_en;
  int unsigned      mismatches;
  int unsigned      words_sent;
  int unsigned      ranks_checked;
  int unsigned      sets_ranked;
  int unsigned      sets_overflowed;

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // store one accepted value and, on the final one, rank the whole set
  task automatic predict_ranks(input sample_t value, input logic is_final);
    rank_word_t  word;
    int unsigned smaller;
    if (set_count < rnka_pkg::CAPACITY) begin
      set_values[set_count] = value;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (is_final) begin
      for (int i = 0; i < set_count; i++) begin
        smaller = 0;
        for (int j = 0; j < set_count; j++)
          if (set_values[j] < set_values[i]) smaller++;
        word.position   = rnka_pkg::POS_W'(i);
        word.rank       = rnka_pkg::RANK_W'(smaller + 1);
        word.final_rank = (i + 1 == set_count);
        word.overflowed = set_dropped;
        pending_ranks.push_back(word);
      end
      sets_ranked++;
      if (set_dropped) sets_overflowed++;
      set_count   = 0;
      set_dropped = 1'b0;
    end
  endtask

  // send one sample word, with an optional idle burst ahead of it
  task automatic send_sample(input sample_t value, input logic is_final);
    int unsigned gap;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      samples_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples_ch.valid        <= 1'b1;
    samples_ch.sample       <= value;
    samples_ch.final_sample <= is_final;
    do @(posedge clk); while (!samples_ch.ready);
    words_sent++;
    predict_ranks(value, is_final);
  endtask

  // send a whole set, the last value marked final
  task automatic send_set(input sample_t values [$]);
    foreach (values[k])
      send_sample(values[k], k == values.size() - 1);
  endtask

  function automatic sample_t pick_value(input int unsigned mode);
    sample_t r;
    r = $urandom();
    case (mode)
      0: pick_value = r;
      1: pick_value = sample_t'($urandom_range(0, 6)) - 3;
      default: begin
        case (r[1:0])
          2'd0: pick_value = {1'b1, {(rnka_pkg::DATA_W-1){1'b0}}};
          2'd1: pick_value = {1'b0, {(rnka_pkg::DATA_W-1){1'b1}}};
          2'd2: pick_value = '1;
          default: pick_value = '0;
        endcase
      end
    endcase
  endfunction

  task automatic test_extremes();
    sample_t vals [$];
    vals = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sh1, 32'sh1, 32'sh5555_5555,
             32'shaaaa_aaaa};
    send_set(vals);
  endtask

  task automatic test_single_value();
    sample_t vals [$];
    vals = '{32'sh1234_5678};
    send_set(vals);
    vals = '{32'sh8000_0000};
    send_set(vals);
  endtask

  task automatic test_duplicates();
    sample_t vals [$];
    vals = '{32'sh5, 32'sh5, -32'sh3, 32'sh5, -32'sh3, 32'sh7fff_ffff, 32'sh7fff_ffff};
    send_set(vals);
    vals = '{-32'sh1, -32'sh1, -32'sh1};
    send_set(vals);
  endtask

  // fill the store with distinct values, then drop two more and the final one
  task automatic test_overflow();
    sample_t     vals [$];
    sample_t     r;
    int unsigned perm_step;
    perm_step = 2 * $urandom_range(0, 31) + 1;
    for (int i = 0; i < rnka_pkg::CAPACITY; i++) begin
      r = $urandom();
      vals.push_back({r[rnka_pkg::DATA_W-1:rnka_pkg::POS_W],
                      rnka_pkg::POS_W'(i * perm_step)});
    end
    for (int i = 0; i < 3; i++) vals.push_back(pick_value(0));
    send_set(vals);
  endtask

  // short sets of random size and content, mostly with duplicates likely
  task automatic test_random_sets(input int unsigned item_budget);
    sample_t     vals [$];
    int unsigned sent;
    int unsigned size;
    int unsigned mode;
    sent = 0;
    while (sent < item_budget) begin
      size = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      mode = $urandom_range(0, 2);
      vals.delete();
      repeat (size) vals.push_back(pick_value(mode));
      send_set(vals);
      sent += size;
    end
  endtask

  // sink side: random stall bursts
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    results_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        stall_left--;
        results_ch.ready <= 1'b0;
      end else if (snk_stall_en && !rst && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 6);
        results_ch.ready <= 1'b0;
      end else begin
        results_ch.ready <= 1'b1;
      end
    end
  end

  // compare each ranked word with the oldest expectation
  always @(posedge clk) begin
    rank_word_t want;
    if (!rst && results_ch.valid && results_ch.ready) begin
      ranks_checked++;
      if (pending_ranks.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word pos=%0d rank=%0d final=%0b ovf=%0b", $time,
                 results_ch.position, results_ch.rank, results_ch.final_rank,
                 results_ch.overflowed);
      end else begin
        want = pending_ranks.pop_front();
        if (results_ch.position !== want.position) begin
          mismatches++;
          $display("%0t: position expected %0d, got %0d", $time, want.position,
                   results_ch.position);
        end
        if (results_ch.rank !== want.rank) begin
          mismatches++;
          $display("%0t: rank at pos %0d expected %0d, got %0d", $time, want.position,
                   want.rank, results_ch.rank);
        end
        if (results_ch.final_rank !== want.final_rank) begin
          mismatches++;
          $display("%0t: final_rank at pos %0d expected %0b, got %0b", $time,
                   want.position, want.final_rank, results_ch.final_rank);
        end
        if (results_ch.overflowed !== want.overflowed) begin
          mismatches++;
          $display("%0t: overflowed at pos %0d expected %0b, got %0b", $time,
                   want.position, want.overflowed, results_ch.overflowed);
        end
      end
    end
  end

  // watchdog: end the run when no word moves for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (samples_ch.valid && samples_ch.ready) ||
          (results_ch.valid && results_ch.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d ranks outstanding", $time,
                 quiet, pending_ranks.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    set_count       = 0;
    set_dropped     = 1'b0;
    mismatches      = 0;
    words_sent      = 0;
    ranks_checked   = 0;
    sets_ranked     = 0;
    sets_overflowed = 0;
    src_idle_en     = 1'b1;
    snk_stall_en    = 1'b1;
    rst                     <= 1'b1;
    samples_ch.valid        <= 1'b0;
    samples_ch.sample       <= '0;
    samples_ch.final_sample <= 1'b0;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_extremes();
    test_single_value();
    test_duplicates();
    test_overflow();
    test_random_sets(30);

    // hold both sides busy for the last sets
    src_idle_en  = 1'b0;
    snk_stall_en = 1'b0;
    test_random_sets(10);

    samples_ch.valid <= 1'b0;
    while (pending_ranks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ranked %0d sets (%0d with dropped values) from %0d samples, %0d words checked.",
             sets_ranked, sets_overflowed, words_sent, ranks_checked);
    $display("Covered extreme values, single-value sets, ties, a full store and idle bursts.");
    if (mismatches == 0 && pending_ranks.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/rnka_pkg.sv
rtl/core/rnka_in_if.sv
rtl/core/rnka_out_if.sv
rtl/core/rnka_ctrl.sv
rtl/core/rnka_dpath.sv
rtl/core/rank_assignment.sv
tb/sv/rank_assignment_tb.sv
